// ===== sv/lss_pkg.sv =====
package lss_pkg;

  localparam int W           = 32;
  localparam int ROWS        = 4;
  localparam int STORE_DEPTH = 96;
  localparam int CA_W        = 7;
  localparam int LAT_DEPTH   = 2 * ROWS;
  localparam int LA_W        = 3;

  localparam int LATENT_DIM_DEF = 4;
  localparam int COVAR_DIM_DEF  = 4;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_INIT = 2'd1;
  localparam logic [1:0] FUNC_STEP = 2'd2;

  localparam logic [2:0] TBL_MEAN  = 3'd0;
  localparam logic [2:0] TBL_INIT  = 3'd1;
  localparam logic [2:0] TBL_ICPT  = 3'd2;
  localparam logic [2:0] TBL_TRAN  = 3'd3;
  localparam logic [2:0] TBL_NOISE = 3'd4;
  localparam logic [2:0] TBL_COVAR = 3'd5;

  typedef logic signed [W-1:0] word_t;
  typedef word_t [ROWS-1:0] vec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_TRAN,
    PH_NOISE,
    PH_COVAR
  } phase_t;

  typedef struct packed {
    logic       vld;
    phase_t     phase;
    logic [1:0] col;
    logic [1:0] row;
    logic       last;
  } tag_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] row;
    word_t      value;
  } wb_t;

endpackage

// ===== sv/lss_in_if.sv =====
interface lss_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [6:0]        coef_addr;
  lss_pkg::word_t    coef_value;
  lss_pkg::word_t    noise_0;
  lss_pkg::word_t    noise_1;
  lss_pkg::word_t    noise_2;
  lss_pkg::word_t    noise_3;
  lss_pkg::word_t    covar_0;
  lss_pkg::word_t    covar_1;
  lss_pkg::word_t    covar_2;
  lss_pkg::word_t    covar_3;

  modport source (
    output valid, func, coef_addr, coef_value,
    output noise_0, noise_1, noise_2, noise_3,
    output covar_0, covar_1, covar_2, covar_3,
    input  ready
  );

  modport sink (
    input  valid, func, coef_addr, coef_value,
    input  noise_0, noise_1, noise_2, noise_3,
    input  covar_0, covar_1, covar_2, covar_3,
    output ready
  );
endinterface

// ===== sv/lss_out_if.sv =====
interface lss_out_if;
  logic           valid;
  logic           ready;
  lss_pkg::word_t latent_0;
  lss_pkg::word_t latent_1;
  lss_pkg::word_t latent_2;
  lss_pkg::word_t latent_3;

  modport source (
    output valid, latent_0, latent_1, latent_2, latent_3,
    input  ready
  );

  modport sink (
    input  valid, latent_0, latent_1, latent_2, latent_3,
    output ready
  );
endinterface

// ===== sv/lss_ram.sv =====
module lss_ram #(
  parameter int WIDTH = lss_pkg::W,
  parameter int DEPTH = lss_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lss_store.sv =====
module lss_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     coef_we,
  input  logic [lss_pkg::CA_W-1:0] coef_waddr,
  input  lss_pkg::word_t           coef_wdata,
  input  logic [lss_pkg::CA_W-1:0] coef_raddr,
  output lss_pkg::word_t           coef_rdata,
  input  logic                     lat_we,
  input  logic [lss_pkg::LA_W-1:0] lat_waddr,
  input  lss_pkg::word_t           lat_wdata,
  input  logic [lss_pkg::LA_W-1:0] lat_raddr,
  output lss_pkg::word_t           lat_rdata
);

  logic [lss_pkg::STORE_DEPTH-1:0] coef_vld_r;
  logic [lss_pkg::LAT_DEPTH-1:0]   lat_vld_r;
  logic                            coef_hit_r;
  logic                            lat_hit_r;
  logic [lss_pkg::W-1:0]           coef_q;
  logic [lss_pkg::W-1:0]           lat_q;

  lss_ram #(
    .WIDTH (lss_pkg::W),
    .DEPTH (lss_pkg::STORE_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  lss_ram #(
    .WIDTH (lss_pkg::W),
    .DEPTH (lss_pkg::LAT_DEPTH)
  ) u_lat_ram (
    .clk   (clk),
    .we    (lat_we),
    .waddr (lat_waddr),
    .wdata (lat_wdata),
    .raddr (lat_raddr),
    .rdata (lat_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      lat_vld_r  <= '0;
    end else begin
      if (coef_we) begin
        coef_vld_r[coef_waddr] <= 1'b1;
      end
      if (lat_we) begin
        lat_vld_r[lat_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_hit_r <= coef_vld_r[coef_raddr];
    lat_hit_r  <= lat_vld_r[lat_raddr];
  end

  // unwritten entries read as zero
  assign coef_rdata = coef_hit_r ? lss_pkg::word_t'(coef_q) : '0;
  assign lat_rdata  = lat_hit_r ? lss_pkg::word_t'(lat_q) : '0;

endmodule

// ===== sv/lss_mac.sv =====
module lss_mac #(
  parameter int FRAC_BITS = lss_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lss_pkg::tag_t  issue,
  input  lss_pkg::word_t coef_rdata,
  input  lss_pkg::word_t lat_rdata,
  input  lss_pkg::vec_t  noise,
  input  lss_pkg::vec_t  covar,
  output lss_pkg::wb_t   wb
);

  localparam int PROD_W = 2 * lss_pkg::W;
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W  = RND_W + 4;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [lss_pkg::W-1:0] ONE = lss_pkg::W'(64'd1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(33'sh07fffffff);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  lss_pkg::tag_t            tag_s1_r, tag_s2_r, tag_s3_r, tag_s4_r;
  logic signed [lss_pkg::W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [PROD_W-1:0] rsum;
  logic signed [RND_W-1:0]  rnd_r;
  logic signed [ACC_W-1:0]  acc_nxt, acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_s1_r <= '0;
      tag_s2_r <= '0;
      tag_s3_r <= '0;
      tag_s4_r <= '0;
    end else begin
      tag_s1_r <= issue;
      tag_s2_r <= tag_s1_r;
      tag_s3_r <= tag_s2_r;
      tag_s4_r <= tag_s3_r;
    end
  end

  // base term multiplies by one, which rounds back to itself
  always_comb begin
    op_a = coef_rdata;
    unique case (tag_s1_r.phase)
      lss_pkg::PH_BASE:  op_b = ONE;
      lss_pkg::PH_TRAN:  op_b = lat_rdata;
      lss_pkg::PH_NOISE: op_b = noise[tag_s1_r.col];
      lss_pkg::PH_COVAR: op_b = covar[tag_s1_r.col];
      default:           op_b = '0;
    endcase
  end

  assign prod_nxt = op_a * op_b;
  assign rsum     = prod_r + HALF;
  assign acc_nxt  = ((tag_s3_r.phase == lss_pkg::PH_BASE) ? ACC_ZERO : acc_r)
                    + ACC_W'(rnd_r);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rnd_r  <= RND_W'(rsum >>> FRAC_BITS);
    if (tag_s3_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    wb.vld = tag_s4_r.vld && tag_s4_r.last;
    wb.row = tag_s4_r.row;
    if (acc_r > SAT_HI) begin
      wb.value = lss_pkg::word_t'(SAT_HI[lss_pkg::W-1:0]);
    end else if (acc_r < SAT_LO) begin
      wb.value = lss_pkg::word_t'(SAT_LO[lss_pkg::W-1:0]);
    end else begin
      wb.value = lss_pkg::word_t'(acc_r[lss_pkg::W-1:0]);
    end
  end

  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    tag_s3_r.vld && tag_s3_r.phase == lss_pkg::PH_BASE |-> !tag_s4_r.vld || tag_s4_r.last)
    else $error("row started before previous row closed");

  a_issue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    issue.vld |-> ##4 tag_s4_r.vld)
    else $error("issued term lost in pipeline");

endmodule

// ===== sv/lss_seq.sv =====
module lss_seq #(
  parameter int LATENT_DIM = lss_pkg::LATENT_DIM_DEF,
  parameter int COVAR_DIM  = lss_pkg::COVAR_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lss_in_if.sink                    in_ch,
  lss_out_if.source                 out_ch,
  output lss_pkg::tag_t             issue,
  output logic [lss_pkg::CA_W-1:0]  coef_raddr,
  output logic [lss_pkg::LA_W-1:0]  lat_raddr,
  output logic                      coef_we,
  output logic [lss_pkg::CA_W-1:0]  coef_waddr,
  output lss_pkg::word_t            coef_wdata,
  output logic                      lat_we,
  output logic [lss_pkg::LA_W-1:0]  lat_waddr,
  output lss_pkg::word_t            lat_wdata,
  output lss_pkg::vec_t             noise,
  output lss_pkg::vec_t             covar,
  input  lss_pkg::wb_t              wb
);

  localparam logic [1:0] LDM1 = 2'(LATENT_DIM - 1);
  localparam logic [1:0] CDM1 = 2'(COVAR_DIM - 1);

  lss_pkg::state_t state_r, state_nxt;
  lss_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      row_r, row_nxt;
  logic [1:0]      col_r, col_nxt;
  logic            init_r, init_nxt;
  logic            bank_r, bank_nxt;
  logic            out_vld_r, out_vld_nxt;
  lss_pkg::vec_t   noise_r, noise_nxt;
  lss_pkg::vec_t   covar_r, covar_nxt;
  lss_pkg::vec_t   res_r, res_nxt;
  lss_pkg::vec_t   out_lat_r, out_lat_nxt;
  logic [2:0]      tbl;
  logic            acc_in;

  assign in_ch.ready = (state_r == lss_pkg::ST_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lss_pkg::ST_IDLE;
      phase_r   <= lss_pkg::PH_BASE;
      row_r     <= '0;
      col_r     <= '0;
      init_r    <= 1'b0;
      bank_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      init_r    <= init_nxt;
      bank_r    <= bank_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    noise_r   <= noise_nxt;
    covar_r   <= covar_nxt;
    res_r     <= res_nxt;
    out_lat_r <= out_lat_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    init_nxt    = init_r;
    bank_nxt    = bank_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    noise_nxt   = noise_r;
    covar_nxt   = covar_r;
    res_nxt     = res_r;
    out_lat_nxt = out_lat_r;
    coef_we     = 1'b0;
    issue       = '0;

    unique case (state_r)
      lss_pkg::ST_IDLE: begin
        if (acc_in) begin
          unique case (in_ch.func) inside
            lss_pkg::FUNC_LOAD: begin
              coef_we = (in_ch.coef_addr < 7'(lss_pkg::STORE_DEPTH));
            end
            lss_pkg::FUNC_INIT, lss_pkg::FUNC_STEP: begin
              init_nxt     = (in_ch.func == lss_pkg::FUNC_INIT);
              noise_nxt[0] = in_ch.noise_0;
              noise_nxt[1] = in_ch.noise_1;
              noise_nxt[2] = in_ch.noise_2;
              noise_nxt[3] = in_ch.noise_3;
              covar_nxt[0] = in_ch.covar_0;
              covar_nxt[1] = in_ch.covar_1;
              covar_nxt[2] = in_ch.covar_2;
              covar_nxt[3] = in_ch.covar_3;
              res_nxt      = '0;
              row_nxt      = '0;
              col_nxt      = '0;
              phase_nxt    = lss_pkg::PH_BASE;
              state_nxt    = lss_pkg::ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      lss_pkg::ST_RUN: begin
        issue.vld   = 1'b1;
        issue.phase = phase_r;
        issue.col   = col_r;
        issue.row   = row_r;
        issue.last  = (phase_r == lss_pkg::PH_COVAR) && (col_r == CDM1);
        unique case (phase_r)
          lss_pkg::PH_BASE: begin
            phase_nxt = init_r ? lss_pkg::PH_NOISE : lss_pkg::PH_TRAN;
            col_nxt   = '0;
          end
          lss_pkg::PH_TRAN: begin
            if (col_r == LDM1) begin
              phase_nxt = lss_pkg::PH_NOISE;
              col_nxt   = '0;
            end else begin
              col_nxt = col_r + 2'd1;
            end
          end
          lss_pkg::PH_NOISE: begin
            if (col_r == LDM1) begin
              phase_nxt = lss_pkg::PH_COVAR;
              col_nxt   = '0;
            end else begin
              col_nxt = col_r + 2'd1;
            end
          end
          lss_pkg::PH_COVAR: begin
            if (col_r == CDM1) begin
              phase_nxt = lss_pkg::PH_BASE;
              col_nxt   = '0;
              if (row_r == LDM1) begin
                state_nxt = lss_pkg::ST_WAIT;
              end else begin
                row_nxt = row_r + 2'd1;
              end
            end else begin
              col_nxt = col_r + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
      lss_pkg::ST_WAIT: begin
      end
      lss_pkg::ST_HOLD: begin
        if (!out_vld_r || out_ch.ready) begin
          out_lat_nxt = res_r;
          out_vld_nxt = 1'b1;
          bank_nxt    = !bank_r;
          state_nxt   = lss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lss_pkg::ST_IDLE;
      end
    endcase

    if (wb.vld) begin
      res_nxt[wb.row] = wb.value;
      if (wb.row == LDM1) begin
        state_nxt = lss_pkg::ST_HOLD;
      end
    end
  end

  always_comb begin
    unique case (phase_r)
      lss_pkg::PH_BASE:  tbl = init_r ? lss_pkg::TBL_MEAN : lss_pkg::TBL_ICPT;
      lss_pkg::PH_TRAN:  tbl = lss_pkg::TBL_TRAN;
      lss_pkg::PH_NOISE: tbl = init_r ? lss_pkg::TBL_INIT : lss_pkg::TBL_NOISE;
      lss_pkg::PH_COVAR: tbl = lss_pkg::TBL_COVAR;
      default:           tbl = lss_pkg::TBL_MEAN;
    endcase
  end

  assign coef_raddr = {tbl, row_r, col_r};
  assign lat_raddr  = {bank_r, col_r};
  assign coef_waddr = in_ch.coef_addr;
  assign coef_wdata = in_ch.coef_value;
  assign lat_we     = wb.vld;
  assign lat_waddr  = {!bank_r, wb.row};
  assign lat_wdata  = wb.value;
  assign noise      = noise_r;
  assign covar      = covar_r;

  assign out_ch.valid    = out_vld_r;
  assign out_ch.latent_0 = out_lat_r[0];
  assign out_ch.latent_1 = out_lat_r[1];
  assign out_ch.latent_2 = out_lat_r[2];
  assign out_ch.latent_3 = out_lat_r[3];

  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wb.vld |-> state_r == lss_pkg::ST_RUN || state_r == lss_pkg::ST_WAIT)
    else $error("row result while sequencer idle");

  a_final_row: assert property (@(posedge clk) disable iff (!rst_n)
    wb.vld && wb.row == LDM1 |=> state_r == lss_pkg::ST_HOLD)
    else $error("final row did not close item");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == lss_pkg::ST_HOLD)
    else $error("output raised outside hold");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    bank_r != $past(bank_r) |-> $past(state_r) == lss_pkg::ST_HOLD)
    else $error("latent bank flipped mid item");

endmodule

// ===== sv/linear_state_space_step.sv =====
// channel   dir  handshake        payload
// in_ch     in   valid / ready    func, coef_addr, coef_value, noise_0..3, covar_0..3
// out_ch    out  valid / ready    latent_0..3
//
// Load item: written straight into the coefficient memory; addresses 96 and up are dropped.
// Initial item: per row, one base term, LATENT_DIM noise terms and COVAR_DIM covar terms;
// step item: the same plus LATENT_DIM transition terms against the previous latent state.
// One coefficient read port and one multiplier set the pace: one term a cycle.
// Reset clears valid bits on both memories; no clearing pass, ready after reset.
// A stalled result holds in the output register; the next load is still taken.
module linear_state_space_step #(
  parameter int LATENT_DIM = lss_pkg::LATENT_DIM_DEF,
  parameter int COVAR_DIM  = lss_pkg::COVAR_DIM_DEF,
  parameter int FRAC_BITS  = lss_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lss_in_if.sink    in_ch,
  lss_out_if.source out_ch
);

  lss_pkg::tag_t             issue;
  lss_pkg::wb_t              wb;
  lss_pkg::vec_t             noise;
  lss_pkg::vec_t             covar;
  logic [lss_pkg::CA_W-1:0]  coef_raddr;
  logic [lss_pkg::CA_W-1:0]  coef_waddr;
  logic [lss_pkg::LA_W-1:0]  lat_raddr;
  logic [lss_pkg::LA_W-1:0]  lat_waddr;
  logic                      coef_we;
  logic                      lat_we;
  lss_pkg::word_t            coef_wdata;
  lss_pkg::word_t            lat_wdata;
  lss_pkg::word_t            coef_rdata;
  lss_pkg::word_t            lat_rdata;

  lss_seq #(
    .LATENT_DIM (LATENT_DIM),
    .COVAR_DIM  (COVAR_DIM)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .issue      (issue),
    .coef_raddr (coef_raddr),
    .lat_raddr  (lat_raddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .lat_we     (lat_we),
    .lat_waddr  (lat_waddr),
    .lat_wdata  (lat_wdata),
    .noise      (noise),
    .covar      (covar),
    .wb         (wb)
  );

  lss_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (coef_raddr),
    .coef_rdata (coef_rdata),
    .lat_we     (lat_we),
    .lat_waddr  (lat_waddr),
    .lat_wdata  (lat_wdata),
    .lat_raddr  (lat_raddr),
    .lat_rdata  (lat_rdata)
  );

  lss_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .coef_rdata (coef_rdata),
    .lat_rdata  (lat_rdata),
    .noise      (noise),
    .covar      (covar),
    .wb         (wb)
  );

endmodule

// ===== tb/linear_state_space_step_tb.sv =====
`timescale 1ns / 1ps

module linear_state_space_step_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int LAT_N = lss_pkg::LATENT_DIM_DEF;
  localparam int COV_N = lss_pkg::COVAR_DIM_DEF;
  localparam int FRAC  = lss_pkg::FRAC_BITS_DEF;
  localparam lss_pkg::word_t Q_ONE  = 32'sh0001_0000;
  localparam lss_pkg::word_t Q_HALF = 32'sh0000_8000;
  localparam lss_pkg::word_t Q_MAX  = 32'sh7fff_ffff;
  localparam lss_pkg::word_t Q_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]     func;
    logic [6:0]     coef_addr;
    lss_pkg::word_t coef_value;
    lss_pkg::vec_t  noise;
    lss_pkg::vec_t  covar;
  } lss_item_t;

  logic clk;
  logic rst_n;

  lss_in_if  in_if ();
  lss_out_if out_if ();

  linear_state_space_step u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  lss_pkg::word_t coef_mem [lss_pkg::STORE_DEPTH];
  lss_pkg::vec_t  latent_state;
  lss_pkg::vec_t  latent_q [$];

  int err_count;
  int n_checked;
  int n_load;
  int n_load_dropped;
  int n_init;
  int n_step;
  int n_unused;
  int n_counted;
  int src_idle_pct;
  int sink_stall_pct;
  int sink_gap;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d latent vectors outstanding", latent_q.size());
    $display("Verification failed");
    $finish;
  end

  function automatic int rand_gap();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic lss_pkg::word_t rand_extreme();
    case ($urandom_range(4))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic lss_pkg::word_t rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 70) return lss_pkg::word_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    if (r < 85) return lss_pkg::word_t'($urandom);
    return rand_extreme();
  endfunction

  function automatic lss_pkg::word_t rand_coef();
    int r;
    r = $urandom_range(99);
    if (r < 80) return lss_pkg::word_t'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
    if (r < 90) return lss_pkg::word_t'($urandom);
    return rand_extreme();
  endfunction

  function automatic lss_item_t make_item(input logic [1:0] f);
    lss_item_t it;
    it.func       = f;
    it.coef_addr  = 7'($urandom_range(0, 127));
    it.coef_value = lss_pkg::word_t'($urandom);
    for (int c = 0; c < lss_pkg::ROWS; c++) begin
      it.noise[c] = rand_sample();
      it.covar[c] = rand_sample();
    end
    return it;
  endfunction

  function automatic lss_item_t coef_item(input logic [2:0] tbl, input int r, input int c,
                                          input lss_pkg::word_t v);
    lss_item_t it;
    it            = make_item(lss_pkg::FUNC_LOAD);
    it.coef_addr  = 7'(int'(tbl) * 16 + r * 4 + c);
    it.coef_value = v;
    return it;
  endfunction

  function automatic lss_pkg::word_t coef_at(input logic [2:0] tbl, input int r, input int c);
    return coef_mem[int'(tbl) * 16 + r * 4 + c];
  endfunction

  function automatic longint round_product(input lss_pkg::word_t a, input lss_pkg::word_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic lss_pkg::word_t saturate(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return lss_pkg::word_t'(v);
  endfunction

  function automatic lss_pkg::vec_t advance_latent(input lss_item_t it);
    lss_pkg::vec_t nxt;
    longint        acc;
    bit            init_item;
    init_item = (it.func == lss_pkg::FUNC_INIT);
    for (int r = 0; r < lss_pkg::ROWS; r++) begin
      if (r >= LAT_N) begin
        nxt[r] = '0;
      end else begin
        acc = longint'(coef_at(init_item ? lss_pkg::TBL_MEAN : lss_pkg::TBL_ICPT, r, 0));
        for (int c = 0; c < LAT_N; c++) begin
          if (init_item) begin
            acc += round_product(coef_at(lss_pkg::TBL_INIT, r, c), it.noise[c]);
          end else begin
            acc += round_product(coef_at(lss_pkg::TBL_TRAN, r, c), latent_state[c]);
            acc += round_product(coef_at(lss_pkg::TBL_NOISE, r, c), it.noise[c]);
          end
        end
        for (int c = 0; c < COV_N; c++)
          acc += round_product(coef_at(lss_pkg::TBL_COVAR, r, c), it.covar[c]);
        nxt[r] = saturate(acc);
      end
    end
    latent_state = nxt;
    return nxt;
  endfunction

  task automatic apply_item(input lss_item_t it);
    case (it.func) inside
      lss_pkg::FUNC_LOAD: begin
        n_load++;
        if (it.coef_addr < lss_pkg::STORE_DEPTH) begin
          coef_mem[it.coef_addr] = it.coef_value;
          n_counted++;
        end else begin
          n_load_dropped++;
        end
      end
      lss_pkg::FUNC_INIT, lss_pkg::FUNC_STEP: begin
        if (it.func == lss_pkg::FUNC_INIT) n_init++;
        else n_step++;
        n_counted++;
        latent_q.push_back(advance_latent(it));
      end
      default: n_unused++;
    endcase
  endtask

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic send_item(input lss_item_t it);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.func       <= it.func;
    in_if.coef_addr  <= it.coef_addr;
    in_if.coef_value <= it.coef_value;
    in_if.noise_0    <= it.noise[0];
    in_if.noise_1    <= it.noise[1];
    in_if.noise_2    <= it.noise[2];
    in_if.noise_3    <= it.noise[3];
    in_if.covar_0    <= it.covar[0];
    in_if.covar_1    <= it.covar[1];
    in_if.covar_2    <= it.covar[2];
    in_if.covar_3    <= it.covar[3];
    do @(posedge clk); while (!in_if.ready);
    apply_item(it);
    gap = ($urandom_range(99) < src_idle_pct) ? rand_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (latent_q.size() != 0);
  endtask

  task automatic check_result();
    lss_pkg::vec_t want;
    lss_pkg::vec_t got;
    got[0] = out_if.latent_0;
    got[1] = out_if.latent_1;
    got[2] = out_if.latent_2;
    got[3] = out_if.latent_3;
    if (latent_q.size() == 0) begin
      note_failure($sformatf("Unexpected latent vector %h", got));
    end else begin
      want = latent_q.pop_front();
      for (int r = 0; r < lss_pkg::ROWS; r++) begin
        if (got[r] !== want[r])
          note_failure($sformatf("Vector %0d latent_%0d: expected %h, got %h",
                                 n_checked, r, want[r], got[r]));
      end
      n_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result();
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else if (sink_gap > 0) begin
        out_if.ready <= 1'b0;
        sink_gap--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(99) < sink_stall_pct) sink_gap = rand_gap();
      end
    end
  end

  task automatic test_reset_state();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(make_item(FUNC_UNUSED));
    send_item(make_item(lss_pkg::FUNC_STEP));
    send_item(make_item(lss_pkg::FUNC_INIT));
  endtask

  task automatic test_saturation();
    lss_item_t it;
    send_item(coef_item(lss_pkg::TBL_MEAN, 0, 0, Q_MAX));
    send_item(coef_item(lss_pkg::TBL_COVAR, 0, 0, Q_ONE));
    send_item(coef_item(lss_pkg::TBL_MEAN, 1, 0, Q_MIN));
    send_item(coef_item(lss_pkg::TBL_COVAR, 1, 1, -Q_ONE));
    send_item(coef_item(lss_pkg::TBL_INIT, 2, 1, Q_MIN));
    send_item(coef_item(lss_pkg::TBL_INIT, 3, 0, Q_MIN));
    it       = make_item(lss_pkg::FUNC_INIT);
    it.noise = {32'sd0, 32'sd0, Q_MAX, Q_MIN};
    it.covar = {32'sd0, 32'sd0, Q_ONE, Q_ONE};
    send_item(it);
    send_item(coef_item(lss_pkg::TBL_TRAN, 0, 0, Q_ONE));
    send_item(make_item(lss_pkg::FUNC_STEP));
  endtask

  task automatic test_rounding();
    lss_item_t it;
    send_item(coef_item(lss_pkg::TBL_INIT, 2, 2, Q_HALF));
    send_item(coef_item(lss_pkg::TBL_INIT, 3, 3, Q_HALF));
    it       = make_item(lss_pkg::FUNC_INIT);
    it.noise = {-32'sd1, 32'sd1, 32'sd0, 32'sd0};
    it.covar = '0;
    send_item(it);
  endtask

  task automatic test_address_map();
    lss_item_t it;
    it           = make_item(lss_pkg::FUNC_LOAD);
    it.coef_addr = 7'd96;
    send_item(it);
    it.coef_addr = 7'd127;
    send_item(it);
    send_item(coef_item(lss_pkg::TBL_MEAN, 0, 3, Q_MAX));
    send_item(coef_item(lss_pkg::TBL_ICPT, 2, 1, Q_MIN));
    send_item(make_item(lss_pkg::FUNC_INIT));
  endtask

  task automatic test_result_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 300;
    repeat (24) begin
      if ($urandom_range(99) < 25)
        send_item(coef_item(lss_pkg::TBL_TRAN, $urandom_range(0, 3),
                            $urandom_range(0, 3), rand_coef()));
      else send_item(make_item(lss_pkg::FUNC_STEP));
    end
  endtask

  task automatic test_sender_pause();
    wait_for_results();
    repeat (4) send_item(make_item(lss_pkg::FUNC_STEP));
    wait_for_results();
  endtask

  task automatic test_random_runs(input int target);
    lss_item_t it;
    int        r;
    while (n_counted < target) begin
      src_idle_pct   = pick_pct();
      sink_stall_pct = pick_pct();
      repeat ($urandom_range(0, 12)) begin
        it            = make_item(lss_pkg::FUNC_LOAD);
        it.coef_addr  = ($urandom_range(99) < 5) ? 7'($urandom_range(96, 127))
                                                 : 7'($urandom_range(0, 95));
        it.coef_value = rand_coef();
        send_item(it);
      end
      if ($urandom_range(99) < 85) send_item(make_item(lss_pkg::FUNC_INIT));
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(99);
        if (r < 6) begin
          it            = make_item(lss_pkg::FUNC_LOAD);
          it.coef_value = rand_coef();
          send_item(it);
        end else if (r < 9) begin
          send_item(make_item(FUNC_UNUSED));
        end
        send_item(make_item(lss_pkg::FUNC_STEP));
      end
    end
  endtask

  initial begin
    err_count      = 0;
    n_checked      = 0;
    n_load         = 0;
    n_load_dropped = 0;
    n_init         = 0;
    n_step         = 0;
    n_unused       = 0;
    n_counted      = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_gap       = 0;
    hold_cycles    = 0;
    latent_state   = '0;
    for (int i = 0; i < lss_pkg::STORE_DEPTH; i++) coef_mem[i] = '0;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.func       <= lss_pkg::FUNC_LOAD;
    in_if.coef_addr  <= '0;
    in_if.coef_value <= '0;
    in_if.noise_0    <= '0;
    in_if.noise_1    <= '0;
    in_if.noise_2    <= '0;
    in_if.noise_3    <= '0;
    in_if.covar_0    <= '0;
    in_if.covar_1    <= '0;
    in_if.covar_2    <= '0;
    in_if.covar_3    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_saturation();
    test_rounding();
    test_address_map();
    test_result_backpressure();
    test_sender_pause();
    test_random_runs(1150);

    wait_for_results();
    repeat (80) @(posedge clk);
    if (latent_q.size() != 0)
      note_failure($sformatf("%0d latent vectors never arrived", latent_q.size()));

    $display("Covered %0d loads (%0d off the store), %0d initial, %0d step, %0d unused-code items",
             n_load, n_load_dropped, n_init, n_step, n_unused);
    $display("Compared %0d latent vectors, %0d failures", n_checked, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lss_pkg.sv
sv/lss_in_if.sv
sv/lss_out_if.sv
sv/lss_ram.sv
sv/lss_store.sv
sv/lss_mac.sv
sv/lss_seq.sv
sv/linear_state_space_step.sv
tb/linear_state_space_step_tb.sv
